[src/h2r565_pkg.sv]
// ----------------------------------------------------------------------------
// h2r565_pkg
// Shared types and fixed-point constants for the HSV to RGB565 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package h2r565_pkg;

  localparam int FRAC_BITS     = 12;
  localparam int HUE_FRAC_BITS = 6;

  localparam int HUE_W  = 15;
  localparam int SV_W   = 13;
  localparam int CH_W   = 8;
  localparam int PK_W   = 16;

  localparam int ONE    = 1 << FRAC_BITS;
  localparam int SPAN   = 60 << HUE_FRAC_BITS;
  localparam int TURN   = 360 << HUE_FRAC_BITS;

  localparam int REM_W  = $clog2(SPAN);
  localparam int X_W    = $clog2(ONE * SPAN + 1);
  localparam int NUM_W  = SV_W + X_W;
  localparam int Y_W    = NUM_W + CH_W;

  // den = 2^(2F+HF) * 60 = 15 << DEN_SHIFT
  localparam int DEN_SHIFT = 2 * FRAC_BITS + HUE_FRAC_BITS + 2;
  localparam int Z_W       = Y_W - DEN_SHIFT;
  localparam logic [Y_W-1:0] HALF_DEN = {{(Y_W-4){1'b0}}, 4'd15} << (DEN_SHIFT - 1);

  // floor(z / 15) = ((z + 1) * RECIP) >> RECIP_SHIFT for the z range here
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = ((1 << RECIP_SHIFT) - 1) / 15;
  localparam int Z_MAX       = 255 * 15 + 7;
  localparam int PQ_W        = Z_W + RECIP_SHIFT;

  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t              sector;
    logic [REM_W-1:0]     rem;
    logic [SV_W-1:0]      sat;
    logic [SV_W-1:0]      val;
    logic                 grey;
  } prep_t;

  typedef struct packed {
    logic [X_W-1:0]       x_r;
    logic [X_W-1:0]       x_g;
    logic [X_W-1:0]       x_b;
    logic [SV_W-1:0]      val;
  } terms_t;

  typedef struct packed {
    logic [CH_W-1:0]      blue;
    logic [CH_W-1:0]      green;
    logic [CH_W-1:0]      red;
  } rgb_t;

endpackage

`default_nettype wire

[src/h2r565_hue.sv]
// ----------------------------------------------------------------------------
// h2r565_hue
// Clamps saturation and brightness, wraps the hue and splits it into a
// sector and a remainder. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module h2r565_hue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire logic [h2r565_pkg::HUE_W-1:0] up_hue,
  input  wire logic [h2r565_pkg::SV_W-1:0]  up_sat,
  input  wire logic [h2r565_pkg::SV_W-1:0]  up_val,
  output logic                             dn_valid,
  input  wire logic                        dn_ready,
  output h2r565_pkg::prep_t                dn_data
);
  import h2r565_pkg::*;

  logic             vld1_r, vld2_r;
  logic             ld1, ld2;
  logic [HUE_W-1:0] hw_r, hw_nxt;
  logic [SV_W-1:0]  sat1_r, sat1_nxt;
  logic [SV_W-1:0]  val1_r, val1_nxt;
  prep_t            prep_r, prep_nxt;
  logic [2:0]       cnt;
  logic [HUE_W-1:0] rem_full;

  assign ld2      = !vld2_r || dn_ready;
  assign ld1      = !vld1_r || ld2;
  assign up_ready = ld1;
  assign dn_valid = vld2_r;
  assign dn_data  = prep_r;

  always_comb begin
    hw_nxt   = (up_hue >= HUE_W'(TURN)) ? up_hue - HUE_W'(TURN) : up_hue;
    sat1_nxt = (up_sat > SV_W'(ONE)) ? SV_W'(ONE) : up_sat;
    val1_nxt = (up_val > SV_W'(ONE)) ? SV_W'(ONE) : up_val;
  end

  always_comb begin
    cnt = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if (hw_r >= HUE_W'(k * SPAN)) begin
        cnt = cnt + 3'd1;
      end
    end
    rem_full        = hw_r - HUE_W'(int'(cnt) * SPAN);
    prep_nxt.sector = sector_t'(cnt);
    prep_nxt.rem    = rem_full[REM_W-1:0];
    prep_nxt.sat    = sat1_r;
    prep_nxt.val    = val1_r;
    prep_nxt.grey   = (sat1_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      if (ld1) vld1_r <= up_valid;
      if (ld2) vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      hw_r   <= hw_nxt;
      sat1_r <= sat1_nxt;
      val1_r <= val1_nxt;
    end
    if (ld2) begin
      prep_r <= prep_nxt;
    end
  end

  a_rem_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    vld2_r |-> (prep_r.rem < REM_W'(SPAN)))
    else $error("hue remainder outside sector");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (up_valid && ld1) |=> (hw_r < HUE_W'(TURN)))
    else $error("hue not wrapped");

endmodule

`default_nettype wire

[src/h2r565_terms.sv]
// ----------------------------------------------------------------------------
// h2r565_terms
// Forms the p, q and t numerators (over ONE*SPAN) and routes them to the three
// channels by sector, or all ONE*SPAN for a grey word. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module h2r565_terms (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire h2r565_pkg::prep_t up_data,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output h2r565_pkg::terms_t dn_data
);
  import h2r565_pkg::*;

  localparam int PW = SV_W + REM_W;
  localparam logic [X_W-1:0] XV = X_W'(ONE * SPAN);

  logic             vld3_r, vld4_r;
  logic             ld3, ld4;
  logic [X_W-1:0]   srem_r, srem_nxt;
  logic [X_W-1:0]   scomp_r, scomp_nxt;
  logic [X_W-1:0]   xp_r, xp_nxt;
  sector_t          sec3_r;
  logic             grey3_r;
  logic [SV_W-1:0]  val3_r;
  logic [REM_W-1:0] comp;
  logic [PW-1:0]    srem_full, scomp_full, xp_full;
  logic [X_W-1:0]   xq, xt;
  terms_t           terms_r, terms_nxt;

  assign ld4      = !vld4_r || dn_ready;
  assign ld3      = !vld3_r || ld4;
  assign up_ready = ld3;
  assign dn_valid = vld4_r;
  assign dn_data  = terms_r;

  always_comb begin
    comp       = REM_W'(SPAN) - up_data.rem;
    srem_full  = PW'(up_data.sat) * PW'(up_data.rem);
    scomp_full = PW'(up_data.sat) * PW'(comp);
    xp_full    = PW'(SV_W'(ONE) - up_data.sat) * PW'(SPAN);
    srem_nxt   = srem_full[X_W-1:0];
    scomp_nxt  = scomp_full[X_W-1:0];
    xp_nxt     = xp_full[X_W-1:0];
  end

  always_comb begin
    xq            = XV - srem_r;
    xt            = XV - scomp_r;
    terms_nxt.val = val3_r;
    case (sec3_r)
      SEC_RY: begin
        terms_nxt.x_r = XV;   terms_nxt.x_g = xt;   terms_nxt.x_b = xp_r;
      end
      SEC_YG: begin
        terms_nxt.x_r = xq;   terms_nxt.x_g = XV;   terms_nxt.x_b = xp_r;
      end
      SEC_GC: begin
        terms_nxt.x_r = xp_r; terms_nxt.x_g = XV;   terms_nxt.x_b = xt;
      end
      SEC_CB: begin
        terms_nxt.x_r = xp_r; terms_nxt.x_g = xq;   terms_nxt.x_b = XV;
      end
      SEC_BM: begin
        terms_nxt.x_r = xt;   terms_nxt.x_g = xp_r; terms_nxt.x_b = XV;
      end
      default: begin
        terms_nxt.x_r = XV;   terms_nxt.x_g = xp_r; terms_nxt.x_b = xq;
      end
    endcase
    if (grey3_r) begin
      terms_nxt.x_r = XV;
      terms_nxt.x_g = XV;
      terms_nxt.x_b = XV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      if (ld3) vld3_r <= up_valid;
      if (ld4) vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      srem_r  <= srem_nxt;
      scomp_r <= scomp_nxt;
      xp_r    <= xp_nxt;
      sec3_r  <= up_data.sector;
      grey3_r <= up_data.grey;
      val3_r  <= up_data.val;
    end
    if (ld4) begin
      terms_r <= terms_nxt;
    end
  end

  a_grey_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (vld3_r && grey3_r && ld4) |=>
      (terms_r.x_r == XV && terms_r.x_g == XV && terms_r.x_b == XV))
    else $error("grey word with unequal channel terms");

endmodule

`default_nettype wire

[src/h2r565_chan.sv]
// ----------------------------------------------------------------------------
// h2r565_chan
// Scales each channel term by brightness and rounds value*255 half up.
// Three register stages: multiply, scale and shift, divide by 15.
// ----------------------------------------------------------------------------
`default_nettype none

module h2r565_chan (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire h2r565_pkg::terms_t up_data,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output h2r565_pkg::rgb_t   dn_data
);
  import h2r565_pkg::*;

  logic              vld5_r, vld6_r, vld7_r;
  logic              ld5, ld6, ld7;
  logic [X_W-1:0]    x_in [3];
  logic [NUM_W-1:0]  num_r [3];
  logic [NUM_W-1:0]  num_nxt [3];
  logic [Z_W-1:0]    z_r [3];
  logic [Z_W-1:0]    z_nxt [3];
  logic [CH_W-1:0]   ch_r [3];
  logic [CH_W-1:0]   ch_nxt [3];
  logic [Y_W-1:0]    y [3];
  logic [PQ_W-1:0]   prod [3];
  logic [Z_W-1:0]    quo [3];

  assign ld7      = !vld7_r || dn_ready;
  assign ld6      = !vld6_r || ld7;
  assign ld5      = !vld5_r || ld6;
  assign up_ready = ld5;
  assign dn_valid = vld7_r;
  assign dn_data  = '{blue: ch_r[2], green: ch_r[1], red: ch_r[0]};

  assign x_in[0] = up_data.x_r;
  assign x_in[1] = up_data.x_g;
  assign x_in[2] = up_data.x_b;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num_nxt[c] = NUM_W'(up_data.val) * NUM_W'(x_in[c]);
      y[c]       = (Y_W'(num_r[c]) << CH_W) - Y_W'(num_r[c]) + HALF_DEN;
      z_nxt[c]   = y[c][Y_W-1:DEN_SHIFT];
      prod[c]    = (PQ_W'(z_r[c]) + PQ_W'(1)) * PQ_W'(RECIP);
      quo[c]     = prod[c][PQ_W-1:RECIP_SHIFT];
      ch_nxt[c]  = (quo[c] > Z_W'(CH_MAX)) ? CH_MAX : quo[c][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else begin
      if (ld5) vld5_r <= up_valid;
      if (ld6) vld6_r <= vld5_r;
      if (ld7) vld7_r <= vld6_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (ld5) num_r[c] <= num_nxt[c];
      if (ld6) z_r[c]   <= z_nxt[c];
      if (ld7) ch_r[c]  <= ch_nxt[c];
    end
  end

  a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld6_r |-> (z_r[0] <= Z_W'(Z_MAX) && z_r[1] <= Z_W'(Z_MAX) && z_r[2] <= Z_W'(Z_MAX)))
    else $error("scaled channel out of range");

endmodule

`default_nettype wire

[src/hsv_to_rgb565.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb565
// HSV triple to 8-bit red, green, blue and a 5-6-5 packed word.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (lsb first)                       | tuser
//  in_     | in  | hue[14:0] sat[27:15] bright[40:28], 48 bits    | none
//  out_    | out | red[7:0] green[15:8] blue[23:16] p565[39:24]   | none
//
//  One word per clock sustained while out_tready is high. Register stages:
//  hue wrap, sector split, terms, routing, multiply, scale, divide by 15.
//  Reset clears all stage valid bits only.
//  Stalls: a full stage holds while the next holds; empty stages still load,
//  so input is taken while a result waits at the output and a stage is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb565 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // hue, saturation, brightness, pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // red, green, blue, packed565
);
  import h2r565_pkg::*;

  logic   prep_valid, prep_ready;
  prep_t  prep;
  logic   terms_valid, terms_ready;
  terms_t terms;
  rgb_t   rgb;
  logic [PK_W-1:0] packed565;

  h2r565_hue u_hue (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_hue   (in_tdata[HUE_W-1:0]),
    .up_sat   (in_tdata[HUE_W+SV_W-1:HUE_W]),
    .up_val   (in_tdata[HUE_W+2*SV_W-1:HUE_W+SV_W]),
    .dn_valid (prep_valid),
    .dn_ready (prep_ready),
    .dn_data  (prep)
  );

  h2r565_terms u_terms (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prep_valid),
    .up_ready (prep_ready),
    .up_data  (prep),
    .dn_valid (terms_valid),
    .dn_ready (terms_ready),
    .dn_data  (terms)
  );

  h2r565_chan u_chan (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (terms_valid),
    .up_ready (terms_ready),
    .up_data  (terms),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (rgb)
  );

  assign packed565 = {rgb.red[7:3], rgb.green[7:2], rgb.blue[7:3]};
  assign out_tdata = {packed565, rgb.blue, rgb.green, rgb.red};

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output stage");

endmodule

`default_nettype wire
